// ===== sv/otq_pkg.sv =====
// otq_pkg: shared types and codes for the ordered timer queue.
// Request/response words, opcodes, result kinds, controller command and status.
// No dependencies.
`default_nettype none

package otq_pkg;

  localparam logic [2:0] OP_START  = 3'd0;
  localparam logic [2:0] OP_STOP   = 3'd1;
  localparam logic [2:0] OP_REPEAT = 3'd2;
  localparam logic [2:0] OP_TICK   = 3'd3;
  localparam logic [2:0] OP_QUERY  = 3'd4;

  localparam logic [1:0] KIND_ACK   = 2'd0;
  localparam logic [1:0] KIND_FIRED = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [63:0] CLAMP_MAX = 64'd2147483647;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  timer_id;
    logic [63:0] delay;
    logic [63:0] repeat_interval;
    logic [63:0] now;
  } req_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  fired_id;
    logic [63:0] due_in;
    logic [30:0] next_timeout;
    logic        none_pending;
    logic        last;
  } rsp_word_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_ACK,
    EMIT_FIRE,
    EMIT_QUERY
  } emit_t;

  typedef struct packed {
    logic  load_in;
    logic  start_wr;
    logic  stop_wr;
    logic  rep_wr;
    logic  tick_begin;
    logic  scan_init;
    logic  scan_tick;
    logic  rd_scan;
    logic  chk;
    logic  upd;
    logic  rd_q;
    logic  q_due;
    logic  q_next;
    logic  fire;
    emit_t emit;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       out_free;
    logic       cand_end;
    logic       found;
    logic       tick_mode;
  } status_t;

endpackage

`default_nettype wire

// ===== sv/ordered_timer_queue_top.sv =====
// ordered_timer_queue_top: bank of timers reported in deadline order.
// Depends on otq_pkg, otq_ctrl, otq_datapath (which uses otq_ram).
//
//   channel | handshake             | word
//   --------+-----------------------+-----------------------------------------
//   request | req_valid / req_ready | op, timer_id, delay, repeat_interval, now
//   result  | rsp_valid / rsp_ready | kind, fired_id, due_in, next_timeout,
//           |                       |   none_pending, last
//
// One request at a time. Start, stop and set repeat go from decode straight to the
// ack word. A scan reads all N = TIMER_COUNT slots through the deadline/sequence
// RAM read port; a tick runs one scan per expired timer plus a final one, and a
// query runs one scan, then reads the queried slot's deadline and builds its word.
// Reset clears state at once, no clearing pass.
// A held result word stalls the sequence only at the next word it emits.
`default_nettype none

module ordered_timer_queue_top import otq_pkg::*; #(
  parameter int TIMER_COUNT = 16
) (
  input  wire       clk,
  input  wire       rst,
  input  wire       req_valid,
  output logic      req_ready,
  input  req_word_t req,
  output logic      rsp_valid,
  input  wire       rsp_ready,
  output rsp_word_t rsp
);

  cmd_t    cmd;
  status_t st;

  otq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  otq_datapath #(.TIMER_COUNT(TIMER_COUNT)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .st        (st),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ===== sv/otq_ram.sv =====
// otq_ram: generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`default_nettype none

module otq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire                                    clk,
  input  wire                                    we,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire  [WIDTH-1:0]                       wdata,
  input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/otq_datapath.sv =====
// otq_datapath: timer storage, minimum scan, saturating re-arm and result register.
// Depends on otq_pkg and otq_ram; driven by otq_ctrl through cmd_t / status_t.
`default_nettype none

module otq_datapath import otq_pkg::*; #(
  parameter int TIMER_COUNT = 16
) (
  input  wire              clk,
  input  wire              rst,
  input  req_word_t        req,
  input  cmd_t             cmd,
  output status_t          st,
  output logic             rsp_valid,
  input  wire              rsp_ready,
  output rsp_word_t        rsp
);

  localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

  req_word_t              req_r;
  logic [63:0]            cur_time;
  logic [63:0]            seq_cnt;
  logic [TIMER_COUNT-1:0] armed;
  logic [TIMER_COUNT-1:0] written;
  logic [TIMER_COUNT-1:0] done;

  logic [IW-1:0]          idx;
  logic [IW-1:0]          rd_idx;
  logic                   rd_end;
  logic [IW-1:0]          cand_idx;
  logic                   cand_end;
  logic [63:0]            cand_dl;
  logic [63:0]            cand_sq;
  logic                   elig;
  logic [IW-1:0]          best_idx;
  logic [63:0]            best_dl;
  logic [63:0]            best_sq;
  logic                   found;
  logic                   tick_mode;
  logic [63:0]            due_r;
  logic [30:0]            next_r;
  logic                   none_r;

  logic                   id_ok;
  logic [IW-1:0]          id_idx;
  logic [63:0]            dl_rdata;
  logic [63:0]            sq_rdata;
  logic [63:0]            iv_rdata;
  logic [63:0]            addend;
  logic [64:0]            sum;
  logic [63:0]            arm_dl;
  logic                   dl_we;
  logic                   iv_we;
  logic [IW-1:0]          dl_waddr;
  logic [IW-1:0]          dl_raddr;
  logic                   rearm;
  logic                   better;
  logic [63:0]            next_diff;

  assign id_ok  = 32'(req_r.timer_id) < TIMER_COUNT;
  assign id_idx = IW'(req_r.timer_id);

  // shared saturating adder: start uses delay, re-arm uses the stored interval
  assign addend = cmd.start_wr ? req_r.delay : iv_rdata;
  assign sum    = {1'b0, cur_time} + {1'b0, addend};
  assign arm_dl = sum[64] ? '1 : sum[63:0];

  assign rearm    = cmd.fire && (iv_rdata != 64'd0);
  assign dl_we    = (cmd.start_wr && id_ok) || rearm;
  assign dl_waddr = cmd.start_wr ? id_idx : best_idx;
  assign iv_we    = (cmd.start_wr || cmd.rep_wr) && id_ok;
  assign dl_raddr = cmd.rd_q ? id_idx : idx;

  otq_ram #(.WIDTH(64), .DEPTH(TIMER_COUNT)) u_dl_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (arm_dl),
    .raddr (dl_raddr),
    .rdata (dl_rdata)
  );

  otq_ram #(.WIDTH(64), .DEPTH(TIMER_COUNT)) u_sq_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (seq_cnt),
    .raddr (idx),
    .rdata (sq_rdata)
  );

  // interval port always follows the current best slot
  otq_ram #(.WIDTH(64), .DEPTH(TIMER_COUNT)) u_iv_ram (
    .clk   (clk),
    .we    (iv_we),
    .waddr (id_idx),
    .wdata (req_r.repeat_interval),
    .raddr (best_idx),
    .rdata (iv_rdata)
  );

  assign better = !found || (cand_dl < best_dl) ||
                  ((cand_dl == best_dl) && (cand_sq < best_sq));
  assign next_diff = best_dl - cur_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_time  <= '0;
      seq_cnt   <= '0;
      armed     <= '0;
      written   <= '0;
      done      <= '0;
      found     <= 1'b0;
      tick_mode <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.start_wr && id_ok) begin
        armed[id_idx]   <= 1'b1;
        written[id_idx] <= 1'b1;
      end
      if (cmd.stop_wr && id_ok) begin
        armed[id_idx] <= 1'b0;
      end
      if (cmd.tick_begin) begin
        cur_time <= req_r.now;
        done     <= '0;
      end
      if (cmd.fire) begin
        armed[best_idx] <= rearm;
        done[best_idx]  <= 1'b1;
      end
      if (dl_we) begin
        seq_cnt <= seq_cnt + 64'd1;
      end
      if (cmd.scan_init) begin
        found     <= 1'b0;
        tick_mode <= cmd.scan_tick;
      end else if (cmd.upd && elig && better) begin
        found <= 1'b1;
      end
      if (cmd.emit != EMIT_NONE) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_r <= req;
    end
    if (cmd.scan_init) begin
      idx <= '0;
    end else if (cmd.rd_scan) begin
      rd_idx <= idx;
      rd_end <= (idx == IW'(TIMER_COUNT - 1));
      idx    <= idx + IW'(1);
    end
    if (cmd.chk) begin
      cand_idx <= rd_idx;
      cand_end <= rd_end;
      cand_dl  <= dl_rdata;
      cand_sq  <= sq_rdata;
      elig     <= armed[rd_idx] &&
                  (!tick_mode || (!done[rd_idx] && (dl_rdata <= cur_time)));
    end
    if (cmd.upd && elig && better) begin
      best_idx <= cand_idx;
      best_dl  <= cand_dl;
      best_sq  <= cand_sq;
    end
    if (cmd.q_due) begin
      due_r <= (id_ok && written[id_idx] && (dl_rdata > cur_time)) ?
               dl_rdata - cur_time : 64'd0;
    end
    if (cmd.q_next) begin
      none_r <= !found;
      if (found && (best_dl > cur_time)) begin
        next_r <= (next_diff > CLAMP_MAX) ? CLAMP_MAX[30:0] : next_diff[30:0];
      end else begin
        next_r <= '0;
      end
    end
    case (cmd.emit)
      EMIT_ACK: begin
        rsp <= '{kind: KIND_ACK, fired_id: 4'd0, due_in: 64'd0, next_timeout: 31'd0,
                 none_pending: 1'b0, last: 1'b1};
      end
      EMIT_FIRE: begin
        rsp <= '{kind: KIND_FIRED, fired_id: 4'(best_idx), due_in: 64'd0,
                 next_timeout: 31'd0, none_pending: 1'b0, last: 1'b0};
      end
      EMIT_QUERY: begin
        rsp <= '{kind: KIND_QUERY, fired_id: req_r.timer_id, due_in: due_r,
                 next_timeout: next_r, none_pending: none_r, last: 1'b1};
      end
      default: begin
      end
    endcase
  end

  assign st.op        = req_r.op;
  assign st.out_free  = !rsp_valid || rsp_ready;
  assign st.cand_end  = cand_end;
  assign st.found     = found;
  assign st.tick_mode = tick_mode;

  // a result word must never overwrite one that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit != EMIT_NONE) |-> (!rsp_valid || rsp_ready))
    else $error("result emitted over a pending word");

  // a fire needs a winner from the last scan, still armed and not yet fired this tick
  a_fire_found: assert property (@(posedge clk) disable iff (rst)
    cmd.fire |-> (found && armed[best_idx] && !done[best_idx]))
    else $error("fire without a valid winner");

  // an expired word is a non-last fired word whose slot is marked done for this tick
  a_fire_word: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit == EMIT_FIRE) |=> (rsp.kind == KIND_FIRED) && !rsp.last &&
                                done[$past(best_idx)])
    else $error("expired word inconsistent with slot state");

endmodule

`default_nettype wire

// ===== sv/otq_ctrl.sv =====
// otq_ctrl: sequencer for the ordered timer queue.
// Depends on otq_pkg; issues cmd_t to otq_datapath and reads status_t.
`default_nettype none

module otq_ctrl import otq_pkg::*; (
  input  wire     clk,
  input  wire     rst,
  input  wire     req_valid,
  output logic    req_ready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ACK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SCAN_UPD,
    S_FIRE_RD,
    S_FIRE_OUT,
    S_TICK_END,
    S_Q_RD,
    S_Q_DUE,
    S_Q_NEXT,
    S_Q_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.emit   = EMIT_NONE;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (st.op)
          OP_START: begin
            cmd.start_wr = 1'b1;
            state_next   = S_ACK;
          end
          OP_STOP: begin
            cmd.stop_wr = 1'b1;
            state_next  = S_ACK;
          end
          OP_REPEAT: begin
            cmd.rep_wr = 1'b1;
            state_next = S_ACK;
          end
          OP_TICK: begin
            cmd.tick_begin = 1'b1;
            cmd.scan_init  = 1'b1;
            cmd.scan_tick  = 1'b1;
            state_next     = S_SCAN_RD;
          end
          OP_QUERY: begin
            cmd.scan_init = 1'b1;
            state_next    = S_SCAN_RD;
          end
          default: begin
            state_next = S_ACK;
          end
        endcase
      end
      S_ACK, S_TICK_END: begin
        if (st.out_free) begin
          cmd.emit   = EMIT_ACK;
          state_next = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        cmd.rd_scan = 1'b1;
        state_next  = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.chk    = 1'b1;
        state_next = S_SCAN_UPD;
      end
      S_SCAN_UPD: begin
        cmd.upd = 1'b1;
        if (!st.cand_end) begin
          cmd.rd_scan = 1'b1;
          state_next  = S_SCAN_CHK;
        end else if (st.tick_mode) begin
          state_next = S_FIRE_RD;
        end else begin
          state_next = S_Q_RD;
        end
      end
      S_FIRE_RD: begin
        // interval port follows the winner; data is ready next cycle
        state_next = st.found ? S_FIRE_OUT : S_TICK_END;
      end
      S_FIRE_OUT: begin
        if (st.out_free) begin
          cmd.emit      = EMIT_FIRE;
          cmd.fire      = 1'b1;
          cmd.scan_init = 1'b1;
          cmd.scan_tick = 1'b1;
          state_next    = S_SCAN_RD;
        end
      end
      S_Q_RD: begin
        cmd.rd_q   = 1'b1;
        state_next = S_Q_DUE;
      end
      S_Q_DUE: begin
        cmd.q_due  = 1'b1;
        state_next = S_Q_NEXT;
      end
      S_Q_NEXT: begin
        cmd.q_next = 1'b1;
        state_next = S_Q_OUT;
      end
      S_Q_OUT: begin
        if (st.out_free) begin
          cmd.emit   = EMIT_QUERY;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench: self-checking bench for ordered_timer_queue_top.
// Keeps its own timer bank model, predicts every result word and checks it in order.
// Depends on otq_pkg and the ordered_timer_queue_top RTL.
`timescale 1ns / 100ps

module testbench;
  import otq_pkg::*;

  localparam int SLOTS = 16;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_PAD = 120;

  logic      clk;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_word_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_word_t rsp;

  int send_idle_pct = 0;
  int rsp_idle_pct = 0;
  int fail_count = 0;
  int quiet_cycles = 0;
  logic [63:0] stim_time = '0;

  // timer bank model
  bit [63:0] bank_deadline [SLOTS];
  bit [63:0] bank_interval [SLOTS];
  bit [63:0] bank_seq [SLOTS];
  bit        bank_armed [SLOTS];
  bit [63:0] clock_now = '0;
  bit [63:0] seq_next = '0;
  rsp_word_t awaited_rsp [$];
  rsp_word_t want;

  ordered_timer_queue_top #(.TIMER_COUNT(SLOTS)) uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic void arm_slot(input int slot, input logic [63:0] span);
    bank_deadline[slot] = add_sat(clock_now, span);
    bank_seq[slot] = seq_next;
    seq_next = seq_next + 64'd1;
    bank_armed[slot] = 1'b1;
  endfunction

  // earliest armed slot by deadline, then sequence, then slot; -1 if none
  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (bank_armed[i]) begin
        if (best < 0 || bank_deadline[i] < bank_deadline[best] ||
            (bank_deadline[i] == bank_deadline[best] && bank_seq[i] < bank_seq[best]))
          best = i;
      end
    end
    return best;
  endfunction

  task automatic advance_timer_bank(input req_word_t w);
    rsp_word_t r;
    rsp_word_t f;
    int m;
    int n;
    int order [SLOTS];
    logic [63:0] d;
    r = '0;
    r.last = 1'b1;
    case (w.op)
      OP_START: begin
        if (w.timer_id < SLOTS) begin
          bank_interval[w.timer_id] = w.repeat_interval;
          arm_slot(w.timer_id, w.delay);
        end
        awaited_rsp.push_back(r);
      end
      OP_STOP: begin
        if (w.timer_id < SLOTS) bank_armed[w.timer_id] = 1'b0;
        awaited_rsp.push_back(r);
      end
      OP_REPEAT: begin
        if (w.timer_id < SLOTS) bank_interval[w.timer_id] = w.repeat_interval;
        awaited_rsp.push_back(r);
      end
      OP_TICK: begin
        clock_now = w.now;
        n = 0;
        m = earliest_slot();
        while (m >= 0 && n < SLOTS && bank_deadline[m] <= clock_now) begin
          bank_armed[m] = 1'b0;
          order[n] = m;
          n++;
          f = '0;
          f.kind = KIND_FIRED;
          f.fired_id = 4'(m);
          awaited_rsp.push_back(f);
          m = earliest_slot();
        end
        // re-arm only after every expiry is reported, in firing order
        for (int k = 0; k < n; k++) begin
          if (bank_interval[order[k]] != 0) arm_slot(order[k], bank_interval[order[k]]);
        end
        awaited_rsp.push_back(r);
      end
      OP_QUERY: begin
        m = earliest_slot();
        r.kind = KIND_QUERY;
        r.fired_id = w.timer_id;
        if (w.timer_id < SLOTS && bank_deadline[w.timer_id] > clock_now)
          r.due_in = bank_deadline[w.timer_id] - clock_now;
        if (m < 0) begin
          r.none_pending = 1'b1;
        end else if (bank_deadline[m] > clock_now) begin
          d = bank_deadline[m] - clock_now;
          r.next_timeout = (d > CLAMP_MAX) ? CLAMP_MAX[30:0] : d[30:0];
        end
        awaited_rsp.push_back(r);
      end
      default: begin
        awaited_rsp.push_back(r);
      end
    endcase
  endtask

  // predict on every accepted request word, check every accepted result word
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) advance_timer_bank(req);
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsp.size() == 0) begin
          $error("result word with nothing awaited: %p", rsp);
          fail_count++;
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.kind !== want.kind) begin
            $error("kind expected %0d actual %0d", want.kind, rsp.kind);
            fail_count++;
          end
          if (rsp.fired_id !== want.fired_id) begin
            $error("fired_id expected %0d actual %0d", want.fired_id, rsp.fired_id);
            fail_count++;
          end
          if (rsp.due_in !== want.due_in) begin
            $error("due_in expected %0d actual %0d", want.due_in, rsp.due_in);
            fail_count++;
          end
          if (rsp.next_timeout !== want.next_timeout) begin
            $error("next_timeout expected %0d actual %0d", want.next_timeout, rsp.next_timeout);
            fail_count++;
          end
          if (rsp.none_pending !== want.none_pending) begin
            $error("none_pending expected %0d actual %0d", want.none_pending, rsp.none_pending);
            fail_count++;
          end
          if (rsp.last !== want.last) begin
            $error("last expected %0d actual %0d", want.last, rsp.last);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) rsp_ready <= 1'b0;
    else rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_span();
    int k;
    k = $urandom_range(99);
    if (k < 8) return rand64();
    if (k < 20) return 64'($urandom_range(100000));
    return 64'($urandom_range(60));
  endfunction

  function automatic req_word_t make_word(input logic [2:0] op, input logic [3:0] id,
                                          input logic [63:0] dly, input logic [63:0] rpt,
                                          input logic [63:0] t);
    req_word_t w;
    w.op = op;
    w.timer_id = id;
    w.delay = dly;
    w.repeat_interval = rpt;
    w.now = t;
    return w;
  endfunction

  // valid stays high after acceptance only until the next call or wait lowers it
  task automatic send_word(input req_word_t w);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= w;
    req_valid <= 1'b1;
    if (w.op == OP_TICK) stim_time = w.now;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic await_all_results();
    req_valid <= 1'b0;
    do @(negedge clk); while (awaited_rsp.size() != 0);
    @(posedge clk);
  endtask

  task automatic reset_state_test();
    send_word(make_word(OP_QUERY, 4'd3, '0, '0, '0));
    send_word(make_word(OP_QUERY + 3'd1, 4'd15, '1, '1, '1));
    send_word(make_word(OP_QUERY + 3'd3, 4'd0, '0, '0, '0));
  endtask

  task automatic saturation_test();
    send_word(make_word(OP_TICK, 4'd0, '0, '0, 64'd100));
    send_word(make_word(OP_START, 4'd0, '1, '0, '0));
    send_word(make_word(OP_QUERY, 4'd0, '0, '0, '0));
    send_word(make_word(OP_START, 4'd15, '0, '1, '0));
    send_word(make_word(OP_QUERY, 4'd15, '0, '0, '0));
    send_word(make_word(OP_TICK, 4'd0, '0, '0, 64'd100));
    // slot 15 re-arms at all ones, equal to now, and must not fire twice
    send_word(make_word(OP_TICK, 4'd0, '0, '0, '1));
    send_word(make_word(OP_QUERY, 4'd15, '0, '0, '0));
    send_word(make_word(OP_STOP, 4'd15, '0, '0, '0));
    send_word(make_word(OP_TICK, 4'd0, '0, '0, '0));
  endtask

  task automatic ordering_test();
    send_word(make_word(OP_TICK, 4'd0, '0, '0, 64'd1000));
    send_word(make_word(OP_START, 4'd9, 64'd20, '0, '0));
    send_word(make_word(OP_START, 4'd2, 64'd20, '0, '0));
    send_word(make_word(OP_START, 4'd5, 64'd10, '0, '0));
    // restart of an armed slot takes a later sequence, so 2 now precedes 9
    send_word(make_word(OP_START, 4'd9, 64'd20, '0, '0));
    send_word(make_word(OP_START, 4'd7, 64'd30, '0, '0));
    send_word(make_word(OP_STOP, 4'd7, '0, '0, '0));
    send_word(make_word(OP_QUERY, 4'd7, '0, '0, '0));
    send_word(make_word(OP_REPEAT, 4'd5, '0, 64'd7, '0));
    send_word(make_word(OP_TICK, 4'd0, '0, '0, 64'd1025));
    send_word(make_word(OP_QUERY, 4'd5, '0, '0, '0));
    send_word(make_word(OP_TICK, 4'd0, '0, '0, 64'd1040));
    send_word(make_word(OP_STOP, 4'd5, '0, '0, '0));
    send_word(make_word(OP_QUERY, 4'd5, '0, '0, '0));
  endtask

  task automatic full_bank_test();
    logic [63:0] rpt;
    for (int i = 0; i < SLOTS; i++) begin
      rpt = (i % 3 == 0) ? 64'($urandom_range(50, 1)) : '0;
      send_word(make_word(OP_START, 4'(i), 64'($urandom_range(30)), rpt, rand64()));
    end
    send_word(make_word(OP_TICK, 4'($urandom_range(15)), rand64(), rand64(),
                        stim_time + 64'd40));
  endtask

  task automatic random_traffic_test(input int count);
    req_word_t w;
    int pick;
    int k;
    for (int i = 0; i < count; i++) begin
      w.timer_id = 4'($urandom_range(15));
      w.delay = pick_span();
      w.repeat_interval = ($urandom_range(99) < 45) ? '0 : pick_span();
      w.now = rand64();
      pick = $urandom_range(99);
      if (pick < 34) w.op = OP_START;
      else if (pick < 44) w.op = OP_STOP;
      else if (pick < 54) w.op = OP_REPEAT;
      else if (pick < 80) w.op = OP_TICK;
      else if (pick < 95) w.op = OP_QUERY;
      else w.op = OP_QUERY + 3'($urandom_range(3, 1));
      if (w.op == OP_TICK) begin
        k = $urandom_range(99);
        if (k < 4) w.now = rand64();
        else if (k < 8) w.now = stim_time;
        else w.now = stim_time + 64'($urandom_range(45, 1));
      end
      send_word(w);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 18;
    rsp_idle_pct = 70;
    reset_state_test();
    saturation_test();
    ordering_test();
    full_bank_test();
    random_traffic_test(100);
    await_all_results();
    send_idle_pct = 70;
    rsp_idle_pct = 18;
    random_traffic_test(100);
    full_bank_test();
    send_idle_pct = 0;
    rsp_idle_pct = 0;
    random_traffic_test(70);
    await_all_results();
    repeat (DRAIN_PAD) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/otq_pkg.sv
sv/otq_ram.sv
sv/otq_datapath.sv
sv/otq_ctrl.sv
sv/ordered_timer_queue_top.sv
tb/sv/testbench.sv
